// ===== rtl/motor_mode_and_position_sequencer_unit_macros.svh =====
// Assertion helpers shared by the RTL of the motor sequencer.
`ifndef MOTOR_MODE_AND_POSITION_SEQUENCER_UNIT_MACROS_SVH
`define MOTOR_MODE_AND_POSITION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, ignored while i_rst_n is low
`define MMPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmps: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, ignored while i_rst_n is low
`define MMPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmps: next-cycle check failed");

`endif

// ===== rtl/mmps_pkg.sv =====
package mmps_pkg;

    // Width of the dwell tick counter
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned DWELL_WIDTH = 16;
    localparam int unsigned CMP_WIDTH   =
        (COUNT_WIDTH > DWELL_WIDTH) ? COUNT_WIDTH : DWELL_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [DWELL_WIDTH-1:0] t_dwell;
    typedef logic [CMP_WIDTH-1:0]   t_cmp;

    // Operating modes
    localparam logic [1:0] MODE_DC   = 2'd0;
    localparam logic [1:0] MODE_SEQ  = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;
    localparam logic [1:0] MODE_FULL = 2'd3;

    // DC motor drive codes
    localparam logic [1:0] DRV_OFF   = 2'd0;
    localparam logic [1:0] DRV_RIGHT = 2'd1;
    localparam logic [1:0] DRV_LEFT  = 2'd2;

    // Sequencer steps
    localparam logic [2:0] STEP_IDLE     = 3'd0;
    localparam logic [2:0] STEP_TO_S3    = 3'd1;
    localparam logic [2:0] STEP_DWELL_S3 = 3'd2;
    localparam logic [2:0] STEP_DWELL_S2 = 3'd3;
    localparam logic [2:0] STEP_DWELL_S1 = 3'd4;
    localparam logic [2:0] STEP_TO_S1    = 3'd5;
    localparam logic [2:0] STEP_ABORT    = 3'd6;

    // Sensor words
    localparam logic [3:0] SENS_S1 = 4'h1;
    localparam logic [3:0] SENS_S2 = 4'h2;
    localparam logic [3:0] SENS_S3 = 4'h4;
    localparam logic [3:0] SENS_S4 = 4'h8;

    // Coil positions
    localparam logic [2:0] POS_FIRST = 3'd1;
    localparam logic [2:0] POS_LAST  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DWELL_THIRD  = 2'd0;
    localparam logic [1:0] REG_DWELL_SECOND = 2'd1;
    localparam logic [1:0] REG_DWELL_FIRST  = 2'd2;

    localparam t_dwell DWELL_THIRD_RST  = 16'd300;
    localparam t_dwell DWELL_SECOND_RST = 16'd500;
    localparam t_dwell DWELL_FIRST_RST  = 16'd100;

    // Whole sequencer state
    typedef struct packed {
        logic [1:0] mode;
        logic       mode_prev;
        logic [2:0] step;
        logic       arrived;
        t_count     dwell;
        logic [2:0] coil_pos;
        logic       pause;
        logic [1:0] presses;
        logic       stop_prev;
        logic [1:0] drive;
        logic [3:0] coil;
    } t_state;

    // State after reset: everything clear, coils at the first position
    localparam t_state ST_RESET = '{coil_pos: POS_FIRST, default: '0};

    // One result item
    typedef struct packed {
        logic [1:0] drive;
        logic [3:0] coil;
        logic [1:0] mode;
        logic [2:0] step;
        logic       pause;
        logic       last;
    } t_result;

    // Sensor word that ends a step
    function automatic logic [3:0] step_target(input logic [2:0] step);
        logic [3:0] t;
        case (step)
            STEP_TO_S3:    t = SENS_S3;
            STEP_DWELL_S3: t = SENS_S2;
            STEP_DWELL_S1: t = SENS_S4;
            default:       t = SENS_S1;
        endcase
        return t;
    endfunction

    // Move on when the sensors show exactly the target: to the next step, TO_S1 back to TO_S3, abort to idle
    function automatic t_state arrival_test(input t_state s, input logic [3:0] target,
                                            input logic [3:0] sensors);
        t_state r;
        r = s;
        if (sensors == target) begin
            if (s.step == STEP_TO_S1) begin
                r.step  = STEP_TO_S3;
                r.dwell = '0;
            end else if (s.step == STEP_ABORT) begin
                r.step  = STEP_IDLE;
                r.dwell = '0;
                r.drive = DRV_OFF;
            end else begin
                r.step    = s.step + 3'd1;
                r.arrived = 1'b0;
                r.dwell   = '0;
            end
        end
        return r;
    endfunction

    // One poll of the pause loop; pause stays set while still held
    function automatic t_state pause_service(input t_state s, input logic start,
                                             input logic stop);
        t_state r;
        r = s;
        r.drive = DRV_OFF;
        if (stop && !s.stop_prev) begin
            r.presses = s.presses + 2'd1;
        end
        r.stop_prev = stop;
        if (r.presses >= 2'd2) begin
            r.step    = STEP_ABORT;
            r.pause   = 1'b0;
            r.presses = 2'd0;
        end else if (start && !stop) begin
            r.pause   = 1'b0;
            r.presses = 2'd0;
        end
        return r;
    endfunction

    // Drive towards a target, pausing on stop
    function automatic t_state move(input t_state s, input logic [1:0] dir,
                                    input logic [3:0] target, input logic start,
                                    input logic stop, input logic [3:0] sensors);
        t_state r;
        r = s;
        r.drive = dir;
        if (stop) begin
            r.pause = 1'b1;
            r = pause_service(r, start, stop);
        end
        if (!r.pause) begin
            r = arrival_test(r, target, sensors);
        end
        return r;
    endfunction

endpackage

// ===== rtl/motor_mode_and_position_sequencer_unit.sv =====
// Motor mode and position sequencer. Each input item is one poll of the start, stop and
// mode buttons, the four position sensors and the 10 ms tick; the item updates the state
// in the cycle it is accepted and its result lands in a result register, with the second
// half-step pattern held beside it. An item
// can be accepted in every cycle, and most items give one result, so the sustained rate is
// one item per cycle while the output side takes results. A half-step poll with start or stop
// (not both) held gives two results (last_of_run low on the first) and holds off the input
// while the second result waits in the buffer, so the next item is taken only as it leaves.
// The user must write dwell registers through the plain write port only while the block is idle; not enforced.
`include "motor_mode_and_position_sequencer_unit_macros.svh"

module motor_mode_and_position_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_start_pressed,
    input  logic       i_stop_pressed,
    input  logic       i_mode_pressed,
    input  logic [3:0] i_position_sensors,
    input  logic       i_tick,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_motor_drive,
    output logic [3:0] o_coil_pattern,
    output logic [1:0] o_current_mode,
    output logic [2:0] o_sequence_step,
    output logic       o_is_paused,
    output logic       o_last_of_run,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    mmps_pkg::t_state  r_st, n_st;
    mmps_pkg::t_result r_res, n_res;
    logic              r_out_valid;
    logic              r_pend;
    logic [3:0]        r_coil2, n_coil2;
    logic              n_two;
    logic              in_acc;

    mmps_pkg::t_dwell  r_dwell_third, r_dwell_second, r_dwell_first;

    // Accept when the buffer will be empty after this cycle
    assign o_in_ready = !r_out_valid || (i_out_ready && !r_pend);
    assign in_acc     = i_in_valid && o_in_ready;

    // Next state and first result of one poll
    always_comb begin
        logic [2:0]       pos;
        logic [3:0]       bit_one;
        logic [3:0]       target;
        mmps_pkg::t_dwell limit;
        n_st    = r_st;
        n_two   = 1'b0;
        n_coil2 = r_st.coil;
        pos     = r_st.coil_pos;
        bit_one = 4'h0;
        target  = mmps_pkg::step_target(r_st.step);
        limit   = r_dwell_first;
        if (r_st.pause) begin
            // paused: only stop and start count, and the sensors once the pause ends
            n_st = mmps_pkg::pause_service(r_st, i_start_pressed, i_stop_pressed);
            if (!n_st.pause) begin
                n_st = mmps_pkg::arrival_test(n_st, target, i_position_sensors);
            end
        end else begin
            // cycle the mode on a button rising edge
            if (i_mode_pressed && !r_st.mode_prev) begin
                n_st.mode = r_st.mode + 2'd1;
            end
            n_st.mode_prev = i_mode_pressed;
            if (n_st.mode != mmps_pkg::MODE_SEQ) begin
                if (pos < mmps_pkg::POS_FIRST || pos > mmps_pkg::POS_LAST) begin
                    pos = mmps_pkg::POS_FIRST;
                end
                bit_one = 4'h1 << (pos - 3'd1);
                if (i_start_pressed && i_stop_pressed) begin
                    n_st.drive = mmps_pkg::DRV_OFF;
                end else if (i_start_pressed || i_stop_pressed) begin
                    if (n_st.mode == mmps_pkg::MODE_DC) begin
                        n_st.drive = i_start_pressed ? mmps_pkg::DRV_RIGHT : mmps_pkg::DRV_LEFT;
                    end else begin
                        // step the coils one place either way
                        n_st.coil = bit_one;
                        if (i_start_pressed) begin
                            pos = (pos == mmps_pkg::POS_LAST) ? mmps_pkg::POS_FIRST
                                                              : pos + 3'd1;
                        end else begin
                            pos = (pos == mmps_pkg::POS_FIRST) ? mmps_pkg::POS_LAST
                                                               : pos - 3'd1;
                        end
                        if (n_st.mode == mmps_pkg::MODE_HALF) begin
                            n_two   = 1'b1;
                            n_coil2 = bit_one | {bit_one[2:0], bit_one[3]};
                        end
                    end
                end else begin
                    n_st.drive = mmps_pkg::DRV_OFF;
                end
                n_st.coil_pos = pos;
            end else begin
                // position loop
                if (n_st.step == mmps_pkg::STEP_IDLE && i_start_pressed) begin
                    n_st.step = mmps_pkg::STEP_TO_S3;
                end
                case (n_st.step) inside
                    mmps_pkg::STEP_TO_S3: begin
                        n_st = mmps_pkg::move(n_st, mmps_pkg::DRV_RIGHT, mmps_pkg::SENS_S3,
                                              i_start_pressed, i_stop_pressed,
                                              i_position_sensors);
                    end
                    mmps_pkg::STEP_DWELL_S3, mmps_pkg::STEP_DWELL_S2,
                    mmps_pkg::STEP_DWELL_S1: begin
                        if (!n_st.arrived) begin
                            n_st.drive   = mmps_pkg::DRV_OFF;
                            n_st.dwell   = '0;
                            n_st.arrived = 1'b1;
                        end
                        if (i_tick && n_st.dwell != '1) begin
                            n_st.dwell = n_st.dwell + mmps_pkg::t_count'(1);
                        end
                        if (n_st.step == mmps_pkg::STEP_DWELL_S3) begin
                            limit = r_dwell_third;
                        end else if (n_st.step == mmps_pkg::STEP_DWELL_S2) begin
                            limit = r_dwell_second;
                        end
                        if (mmps_pkg::t_cmp'(n_st.dwell) >= mmps_pkg::t_cmp'(limit)) begin
                            n_st = mmps_pkg::move(n_st,
                                (n_st.step == mmps_pkg::STEP_DWELL_S1) ? mmps_pkg::DRV_RIGHT
                                                                       : mmps_pkg::DRV_LEFT,
                                mmps_pkg::step_target(n_st.step),
                                i_start_pressed, i_stop_pressed, i_position_sensors);
                        end
                    end
                    mmps_pkg::STEP_TO_S1, mmps_pkg::STEP_ABORT: begin
                        n_st = mmps_pkg::move(n_st, mmps_pkg::DRV_LEFT, mmps_pkg::SENS_S1,
                                              i_start_pressed, i_stop_pressed,
                                              i_position_sensors);
                    end
                    default: begin
                    end
                endcase
            end
        end
        // first result; a half step shows the single coil first
        n_res.drive = n_st.drive;
        n_res.coil  = n_st.coil;
        n_res.mode  = n_st.mode;
        n_res.step  = n_st.step;
        n_res.pause = n_st.pause;
        n_res.last  = !n_two;
        if (n_two) begin
            n_st.coil = n_coil2;
        end
    end

    // State and result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= mmps_pkg::ST_RESET;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (in_acc) begin
            r_st        <= n_st;
            r_out_valid <= 1'b1;
            r_pend      <= n_two;
        end else if (r_out_valid && i_out_ready) begin
            // advance to the second half-step pattern, or drop the result
            if (r_pend) begin
                r_pend <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res   <= n_res;
            r_coil2 <= n_coil2;
        end else if (r_out_valid && i_out_ready && r_pend) begin
            r_res.coil <= r_coil2;
            r_res.last <= 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_third  <= mmps_pkg::DWELL_THIRD_RST;
            r_dwell_second <= mmps_pkg::DWELL_SECOND_RST;
            r_dwell_first  <= mmps_pkg::DWELL_FIRST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mmps_pkg::REG_DWELL_THIRD:  r_dwell_third  <= i_cfg_data;
                mmps_pkg::REG_DWELL_SECOND: r_dwell_second <= i_cfg_data;
                mmps_pkg::REG_DWELL_FIRST:  r_dwell_first  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_drive   = r_res.drive;
    assign o_coil_pattern  = r_res.coil;
    assign o_current_mode  = r_res.mode;
    assign o_sequence_step = r_res.step;
    assign o_is_paused     = r_res.pause;
    assign o_last_of_run   = r_res.last;

    // Checks
    `MMPS_ASSERT_IMP(a_pend_has_front, r_pend, r_out_valid && !r_res.last)
    `MMPS_ASSERT_IMP(a_pause_only_seq, r_st.pause, r_st.mode == mmps_pkg::MODE_SEQ)
    `MMPS_ASSERT_IMP(a_presses_in_pause, !r_st.pause, r_st.presses == 2'd0)
    `MMPS_ASSERT_NXT(a_second_follows, r_pend && i_out_ready, r_out_valid && r_res.last)

endmodule
